### sv/indexed_sequence_store_assert.svh
// Assertion macros shared by the checker of the indexed sequence store.
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IST_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IST_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ist_pkg.sv
// Shared types and constants of the indexed sequence store.
`timescale 1ns / 1ps
package ist_pkg;

	localparam int TYPE_W  = 3;
	localparam int POS_W   = 17;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 9;

	// Request kinds as they arrive on the req_type field.
	localparam logic [TYPE_W-1:0] REQ_READ     = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_INS_HEAD = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_INS_TAIL = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_INS_AT   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Value returned by anything but a successful read.
	localparam logic signed [VALUE_W-1:0] VALUE_NONE = -32'sd1;

	typedef enum logic [1:0] {
		OP_READ,
		OP_INSERT,
		OP_DELETE,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_SHIFT,
		S_COMMIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_req;
		logic setup;
		logic shift;
		logic commit;
		logic ld_res;
	} dp_cmd_t;

	typedef struct packed {
		op_t               op;
		logic [STAT_W-1:0] chk;
		logic              busy;
	} dp_sts_t;

endpackage

### sv/ist_req_if.sv
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
interface ist_req_if;
	import ist_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [TYPE_W-1:0]         req_type;
	logic signed [POS_W-1:0]   position;
	logic signed [VALUE_W-1:0] item_value;

	modport source (output valid, output req_type, output position, output item_value,
		input ready);
	modport sink (input valid, input req_type, input position, input item_value,
		output ready);
endinterface

### sv/ist_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
interface ist_rsp_if;
	import ist_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic [STAT_W-1:0]         status;
	logic [COUNT_W-1:0]        entry_count;

	modport source (output valid, output read_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		output ready);
endinterface

### sv/ist_dp.sv
// Datapath: request registers, entry memory, shift engine and result register.
`timescale 1ns / 1ps
module ist_dp #(
	parameter int CAPACITY = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ist_pkg::dp_cmd_t                  cmd,
	output ist_pkg::dp_sts_t                  sts,
	input  logic [ist_pkg::TYPE_W-1:0]        req_type,
	input  logic signed [ist_pkg::POS_W-1:0]  position,
	input  logic signed [ist_pkg::VALUE_W-1:0] item_value,
	output logic signed [ist_pkg::VALUE_W-1:0] read_value,
	output logic [ist_pkg::STAT_W-1:0]        status,
	output logic [ist_pkg::COUNT_W-1:0]       entry_count
);
	import ist_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = POS_W + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [VALUE_W-1:0] mem [CAPACITY];

	logic [TYPE_W-1:0]         kind_q;
	logic signed [POS_W-1:0]   pos_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             left_q;
	logic                      pend_q;
	logic [AW-1:0]             ptr_q;
	logic [AW-1:0]             wr_q;
	logic [AW-1:0]             put_q;
	logic [STAT_W-1:0]         chk_q;
	logic [VALUE_W-1:0]        rdata_q;
	logic signed [VALUE_W-1:0] res_value_q;
	logic [STAT_W-1:0]         res_status_q;
	logic [COUNT_W-1:0]        res_count_q;

	op_t               op;
	logic [EW-1:0]     eff;
	logic [EW-1:0]     cnt_ext;
	logic [CW-1:0]     eidx;
	logic              ins_ok;
	logic              sel_ok;
	logic              full;
	logic [STAT_W-1:0] chk;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;

	always_comb begin
		unique case (kind_q) inside
			REQ_READ: op = OP_READ;
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: op = OP_INSERT;
			REQ_DELETE: op = OP_DELETE;
			default: op = OP_BAD;
		endcase
	end

	// Effective position, sign extended by one bit so it compares against the count.
	always_comb begin
		cnt_ext = EW'(count_q);
		case (kind_q)
			REQ_INS_HEAD: eff = '0;
			REQ_INS_TAIL: eff = cnt_ext;
			default: eff = {pos_q[POS_W-1], pos_q};
		endcase
		eidx   = eff[CW-1:0];
		ins_ok = !eff[EW-1] && (eff <= cnt_ext);
		sel_ok = !eff[EW-1] && (eff < cnt_ext);
		full   = (count_q == CAP_C);
	end

	always_comb begin
		case (op)
			OP_READ: chk = sel_ok ? ST_DONE : ST_RANGE;
			OP_INSERT: chk = !ins_ok ? ST_RANGE : (full ? ST_FULL : ST_DONE);
			OP_DELETE: chk = sel_ok ? ST_DONE : ST_RANGE;
			default: chk = ST_RANGE;
		endcase
	end

	assign sts.op   = op;
	assign sts.chk  = chk;
	assign sts.busy = (left_q != '0) || pend_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= req_type;
			pos_q  <= position;
			val_q  <= item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			left_q  <= '0;
			pend_q  <= 1'b0;
		end else if (cmd.setup) begin
			pend_q <= 1'b0;
			if (chk != ST_DONE) begin
				left_q <= '0;
			end else if (op == OP_INSERT) begin
				left_q <= count_q - eidx;
			end else if (op == OP_DELETE) begin
				left_q <= count_q - eidx - ONE_C;
			end else begin
				left_q <= '0;
			end
		end else if (cmd.shift) begin
			pend_q <= (left_q != '0);
			if (left_q != '0) begin
				left_q <= left_q - ONE_C;
			end
		end else if (cmd.commit) begin
			if (op == OP_INSERT) begin
				count_q <= count_q + ONE_C;
			end else if (op == OP_DELETE) begin
				count_q <= count_q - ONE_C;
			end
		end
	end

	// Read pointer walks down for an insert and up for a delete; the write
	// address trails it by one place on the far side.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			chk_q <= chk;
			put_q <= AW'(eidx);
			if (op == OP_INSERT) begin
				ptr_q <= AW'(count_q - ONE_C);
			end else if (op == OP_DELETE) begin
				ptr_q <= AW'(eidx + ONE_C);
			end else begin
				ptr_q <= AW'(eidx);
			end
		end else if (cmd.shift && (left_q != '0)) begin
			if (op == OP_INSERT) begin
				ptr_q <= ptr_q - AW'(1);
				wr_q  <= ptr_q + AW'(1);
			end else begin
				ptr_q <= ptr_q + AW'(1);
				wr_q  <= ptr_q - AW'(1);
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q;
		mem_wdata = rdata_q;
		if (cmd.shift && pend_q) begin
			mem_we = 1'b1;
		end else if (cmd.commit && (op == OP_INSERT)) begin
			mem_we    = 1'b1;
			mem_waddr = put_q;
			mem_wdata = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_res) begin
			res_value_q  <= ((op == OP_READ) && (chk_q == ST_DONE)) ? rdata_q : VALUE_NONE;
			res_status_q <= chk_q;
			res_count_q  <= COUNT_W'(count_q);
		end
	end

	assign read_value  = res_value_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

endmodule

### sv/ist_ctrl.sv
// Controller: sequences one request through check, read or shift and commit, and result.
`timescale 1ns / 1ps
module ist_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ist_pkg::dp_sts_t sts,
	output ist_pkg::dp_cmd_t cmd
);
	import ist_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   res_free;

	assign res_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (sts.chk != ST_DONE) begin
					state_nx = S_RESP;
				end else if (sts.op == OP_READ) begin
					state_nx = S_READ;
				end else if ((sts.op == OP_INSERT) || (sts.op == OP_DELETE)) begin
					state_nx = S_SHIFT;
				end else begin
					state_nx = S_RESP;
				end
			end
			S_READ: state_nx = S_RESP;
			S_SHIFT: begin
				if (!sts.busy) state_nx = S_COMMIT;
			end
			S_COMMIT: state_nx = S_RESP;
			S_RESP: begin
				if (res_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		cmd.load_req = (state_q == S_IDLE) && in_valid;
		cmd.setup    = (state_q == S_CHECK);
		cmd.shift    = (state_q == S_SHIFT);
		cmd.commit   = (state_q == S_COMMIT);
		cmd.ld_res   = (state_q == S_RESP) && res_free;
		in_ready     = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.ld_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/indexed_sequence_store.sv
// Top level of the indexed sequence store: controller plus datapath.
`timescale 1ns / 1ps
//
//   Channel | Direction | Beat contents
//   --------+-----------+------------------------------------------
//   req     | in        | req_type, position, item_value
//   rsp     | out       | read_value, status, entry_count
//
// A read passes the check, read and result states; the next beat is taken back in idle.
// An insert or delete passes the check, shift, commit and result states, moving each
// entry after its position by one place. The single memory port pair paces the shift: one entry is
// read and at most one entry is written in every shift cycle.
// Reset empties the store at once; the entry memory itself is not cleared.
// A result waits in its own register while the next beat is accepted.
module indexed_sequence_store #(
	parameter int CAPACITY = 256
) (
	input logic       clk,
	input logic       arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);
	import ist_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller walks each request through its states and tells the
	// datapath when to latch, shift, commit and present the result.
	ist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the entry memory, the count and the shift engine that
	// opens or closes a gap one entry per cycle.
	ist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.position    (req.position),
		.item_value  (req.item_value),
		.read_value  (rsp.read_value),
		.status      (rsp.status),
		.entry_count (rsp.entry_count)
	);

endmodule

### sv/ist_checker.sv
// Port-level checker of the indexed sequence store and its bind statement.
`timescale 1ns / 1ps
`include "indexed_sequence_store_assert.svh"
module ist_checker #(
	parameter int CAPACITY = 256
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [ist_pkg::VALUE_W-1:0] rsp_read_value,
	input logic [ist_pkg::STAT_W-1:0]         rsp_status,
	input logic [ist_pkg::COUNT_W-1:0]        rsp_entry_count
);
	import ist_pkg::*;

	localparam logic [COUNT_W-1:0] CAP_SHOWN = COUNT_W'(CAPACITY);

	// A result beat that is not taken stays put.
	`IST_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_status) && $stable(rsp_entry_count), "result beat changed while stalled")

	// One request at a time: no second beat right after an accepted one.
	`IST_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready, "request accepted while another is in work")

	// Anything but a done status carries the none value.
	`IST_ASSERT_SAME(a_fail_value, clk, arst_n, rsp_valid && (rsp_status != ST_DONE), rsp_read_value == VALUE_NONE, "failed request returned a value")

	// A full refusal reports a store at capacity.
	`IST_ASSERT_SAME(a_full_count, clk, arst_n, rsp_valid && (rsp_status == ST_FULL), rsp_entry_count == CAP_SHOWN, "full status with store below capacity")

endmodule

bind indexed_sequence_store ist_checker #(
	.CAPACITY (CAPACITY)
) u_ist_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count)
);
